// ===== sv/slfc_pkg.sv =====
`default_nettype none

package slfc_pkg;

  // Verdict codes reported on the final byte of a buffer
  typedef enum logic [2:0] {
    V_OK         = 3'd0,
    V_NO_HEADER  = 3'd1,
    V_SHORT      = 3'd2,
    V_BAD_STATUS = 3'd3,
    V_TRUNCATED  = 3'd4,
    V_MISMATCH   = 3'd5
  } verdict_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_HEADER     = 2'd0;
  localparam logic [1:0] REG_STATUS_ONE = 2'd1;
  localparam logic [1:0] REG_STATUS_TWO = 2'd2;

  localparam logic [7:0] HEADER_RST     = 8'h55;
  localparam logic [7:0] STATUS_ONE_RST = 8'h90;
  localparam logic [7:0] STATUS_TWO_RST = 8'h00;

  localparam int unsigned CountW     = 17;
  localparam logic [CountW-1:0] COUNT_MAX   = {CountW{1'b1}};
  localparam logic [CountW-1:0] MIN_FRAME   = CountW'(6);
  localparam logic [CountW-1:0] DATA_OFFSET = CountW'(5);

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] status_one;
    logic [7:0] status_two;
  } cfg_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/slfc_core.sv =====
`default_nettype none

module slfc_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  wire  [7:0]           data_byte,
  input  wire                  last_byte,
  input  slfc_pkg::cfg_t       cfg,
  output logic                 res_fire,
  output slfc_pkg::result_t    res
);
  import slfc_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_SW1, PH_SW2, PH_LEN1, PH_LEN2, PH_DATA, PH_CHECK, PH_DONE
  } phase_t;

  phase_t             phase_r, phase_nxt, phase_upd;
  logic [CountW-1:0]  count_r, count_nxt, count_upd, count_inc;
  logic [15:0]        len_r, len_nxt, len_upd;
  logic [7:0]         xor_r, xor_nxt, xor_upd;
  verdict_t           held_r, held_nxt, held_upd;

  assign count_inc = (count_r != COUNT_MAX) ? count_r + CountW'(1) : count_r;

  // frame walk for one accepted byte
  always_comb begin
    phase_upd = phase_r;
    count_upd = count_r;
    len_upd   = len_r;
    xor_upd   = xor_r;
    held_upd  = held_r;
    if (phase_r == PH_HUNT) begin
      if (data_byte == cfg.header_value) begin
        phase_upd = PH_SW1;
        count_upd = CountW'(1);
        len_upd   = '0;
        xor_upd   = '0;
        held_upd  = V_OK;
      end
    end else begin
      count_upd = count_inc;
      unique case (phase_r)
        PH_SW1: begin
          xor_upd   = xor_r ^ data_byte;
          if (data_byte != cfg.status_one) held_upd = V_BAD_STATUS;
          phase_upd = PH_SW2;
        end
        PH_SW2: begin
          xor_upd = xor_r ^ data_byte;
          if (data_byte != cfg.status_two || held_r == V_BAD_STATUS) begin
            held_upd  = V_BAD_STATUS;
            phase_upd = PH_DONE;
          end else begin
            phase_upd = PH_LEN1;
          end
        end
        PH_LEN1: begin
          xor_upd   = xor_r ^ data_byte;
          len_upd   = {data_byte, 8'h00};
          phase_upd = PH_LEN2;
        end
        PH_LEN2: begin
          xor_upd   = xor_r ^ data_byte;
          len_upd   = {len_r[15:8], data_byte};
          phase_upd = ({len_r[15:8], data_byte} == 16'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          xor_upd = xor_r ^ data_byte;
          if (count_inc == {1'b0, len_r} + DATA_OFFSET) phase_upd = PH_CHECK;
        end
        PH_CHECK: begin
          held_upd  = (data_byte == ~xor_r) ? V_OK : V_MISMATCH;
          phase_upd = PH_DONE;
        end
        PH_DONE, PH_HUNT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // verdict on the final byte, then clear for the next buffer
  always_comb begin
    res_fire           = step && last_byte;
    res.payload_length = (phase_upd == PH_LEN2) ? 16'd0 : len_upd;
    if (phase_upd == PH_HUNT)       res.verdict = V_NO_HEADER;
    else if (count_upd < MIN_FRAME) res.verdict = V_SHORT;
    else if (phase_upd == PH_DONE)  res.verdict = held_upd;
    else                            res.verdict = V_TRUNCATED;

    phase_nxt = phase_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    held_nxt  = held_r;
    if (step) begin
      if (last_byte) begin
        phase_nxt = PH_HUNT;
        count_nxt = '0;
        len_nxt   = '0;
        xor_nxt   = '0;
        held_nxt  = V_NO_HEADER;
      end else begin
        phase_nxt = phase_upd;
        count_nxt = count_upd;
        len_nxt   = len_upd;
        xor_nxt   = xor_upd;
        held_nxt  = held_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
      len_r   <= '0;
      xor_r   <= '0;
      held_r  <= V_NO_HEADER;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      held_r  <= held_nxt;
    end
  end

  a_hunt_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HUNT) == (count_r == '0))
    else $error("byte count out of step with header hunt");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> phase_r == PH_HUNT && xor_r == 8'h00)
    else $error("frame state not cleared after final byte");

  a_len_zero_early: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SW1 || phase_r == PH_SW2 || phase_r == PH_LEN1) |-> len_r == 16'd0)
    else $error("length field set before length bytes");

endmodule

`default_nettype wire

// ===== sv/status_frame_lrc_checker.sv =====
// A buffer's result is registered when its final byte is taken, into out_* or, if stalled, the skid entry.
// One byte per cycle while the skid entry is empty; each byte is a compare and an XOR on the frame state registers.
// Results pass through a two-entry output stage, so bytes keep flowing while a result waits.
// Reset (rst_n, synchronous, active low): header hunt, empty output stage, and the
// registers back to header 0x55, status 0x90 / 0x00.
`default_nettype none

module status_frame_lrc_checker (
  input  wire         clk,
  input  wire         rst_n,
  // byte stream
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_last_byte,
  // verdict stream
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_verdict,
  output logic [15:0] out_payload_length,
  // configuration
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_wdata
);
  import slfc_pkg::*;

  cfg_t    cfg_r;
  logic    step;
  logic    res_fire;
  result_t res;

  // output stage: main register plus one skid entry
  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  logic    take;

  // ---------------------------------------------------------------------------
  // Configuration registers; an index off the end of the list is dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value <= HEADER_RST;
      cfg_r.status_one   <= STATUS_ONE_RST;
      cfg_r.status_two   <= STATUS_TWO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER:     cfg_r.header_value <= cfg_wdata;
        REG_STATUS_ONE: cfg_r.status_one   <= cfg_wdata;
        REG_STATUS_TWO: cfg_r.status_two   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Byte intake. Ready only drops when the skid entry is full, i.e. a result
  // is already parked behind a stalled one.
  // ---------------------------------------------------------------------------
  assign in_ready = !skid_valid_r;
  assign step     = in_valid && in_ready;

  slfc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cfg       (cfg_r),
    .res_fire  (res_fire),
    .res       (res)
  );

  // ---------------------------------------------------------------------------
  // Result stage. A new result goes straight to the output register when it
  // is free (or being drained); otherwise it waits in the skid entry.
  // ---------------------------------------------------------------------------
  assign take = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (take || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (res_fire && out_valid_r && !take) begin
      skid_data_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = out_data_r.verdict;
  assign out_payload_length = out_data_r.payload_length;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item with the output register empty");

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire && out_valid_r && !out_ready |=> skid_valid_r)
    else $error("result dropped while output stalled");

  a_verdict_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.verdict <= V_MISMATCH)
    else $error("verdict code out of range");

endmodule

`default_nettype wire
